@@ sv/trrf_pkg.sv @@
package trrf_pkg;

   // Default sizes
   localparam int MOTIF_MAX_DEF  = 8;
   localparam int POS_WIDTH_DEF  = 32;

   // Result queue depth, power of two
   localparam int RSP_DEPTH      = 8;

   // Saturation limit of counts and reported offsets
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // Active configuration handed to the datapath
   typedef struct packed {
      logic [63:0] motif;
      logic [3:0]  motif_length;
      logic        case_fold;
   } cfg_type;

   // One run record
   typedef struct packed {
      logic [31:0] run_start_pos;
      logic [31:0] run_repeats;
      logic [7:0]  left_base;
      logic        has_left;
      logic [7:0]  right_base;
      logic        has_right;
      logic [31:0] match_total;
      logic        region_done;
      logic        last_record;
   } rec_type;

endpackage

@@ sv/tandem_repeat_run_finder.sv @@
// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_stall  req_base, req_region_end
// rsp       out  rsp_valid/rsp_stall  run record fields, rsp_last_record
// csr       in   APB psel/penable     paddr 5b, 64b data, motif @0x00, len @0x08, fold @0x10
//
// One base is taken per cycle while req_stall is low; its records show on rsp
// after the input register and then the record queue.
// A base can end two runs and yield two beats; rsp drains one a cycle, unless
// stalled, from an 8-entry queue, so req_stall rises once that queue could not
// take two more records for every base in flight. rsp_stall only backs up the queue.
// Reset is synchronous and clears run state, queue and registers.
module tandem_repeat_run_finder #(
   parameter int MOTIF_MAX = trrf_pkg::MOTIF_MAX_DEF,
   parameter int POS_WIDTH = trrf_pkg::POS_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_base,
   input  logic        req_region_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_run_start_pos,
   output logic [31:0] rsp_run_repeats,
   output logic [7:0]  rsp_left_base,
   output logic        rsp_has_left,
   output logic [7:0]  rsp_right_base,
   output logic        rsp_has_right,
   output logic [31:0] rsp_match_total,
   output logic        rsp_region_done,
   output logic        rsp_last_record,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import trrf_pkg::*;

   localparam logic [1:0] REG_MOTIF     = 2'd0;
   localparam logic [1:0] REG_MOTIF_LEN = 2'd1;
   localparam logic [1:0] REG_CASE_FOLD = 2'd2;
   localparam int CNT_W = $clog2(RSP_DEPTH+1);
   localparam int SUM_W = CNT_W + 1;

   logic [63:0]      motif_ff;
   logic [3:0]       mlen_ff;
   logic             fold_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;
   cfg_type          cfg;
   logic             take;
   logic             stage_vld;
   logic [1:0]       push_cnt;
   rec_type          rec0, rec1, out_rec;
   logic             pop;
   logic [CNT_W-1:0] q_count;
   logic [SUM_W-1:0] need;

   // Register file
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_ff <= 64'd0;
         mlen_ff  <= 4'd1;
         fold_ff  <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MOTIF:     motif_ff <= pwdata;
            REG_MOTIF_LEN: mlen_ff  <= pwdata[3:0];
            REG_CASE_FOLD: fold_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MOTIF:     prdata = motif_ff;
         REG_MOTIF_LEN: prdata = 64'(mlen_ff);
         REG_CASE_FOLD: prdata = 64'(fold_ff);
         default:       prdata = 64'd0;
      endcase
   end

   assign cfg.motif        = motif_ff;
   assign cfg.motif_length = mlen_ff;
   assign cfg.case_fold    = fold_ff;

   // Reserve queue room for two records per base in flight
   assign need      = SUM_W'(q_count) + (stage_vld ? SUM_W'(2) : SUM_W'(0)) + SUM_W'(2);
   assign req_stall = (need > SUM_W'(RSP_DEPTH));
   assign take      = req_valid && !req_stall;

   trrf_core #(
      .MOTIF_MAX (MOTIF_MAX),
      .POS_WIDTH (POS_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .base       (req_base),
      .region_end (req_region_end),
      .cfg        (cfg),
      .stage_vld  (stage_vld),
      .push_cnt   (push_cnt),
      .rec0       (rec0),
      .rec1       (rec1)
   );

   assign pop = rsp_valid && !rsp_stall;

   trrf_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (rec0),
      .push1     (rec1),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_rec   (out_rec),
      .count     (q_count)
   );

   assign rsp_run_start_pos = out_rec.run_start_pos;
   assign rsp_run_repeats   = out_rec.run_repeats;
   assign rsp_left_base     = out_rec.left_base;
   assign rsp_has_left      = out_rec.has_left;
   assign rsp_right_base    = out_rec.right_base;
   assign rsp_has_right     = out_rec.has_right;
   assign rsp_match_total   = out_rec.match_total;
   assign rsp_region_done   = out_rec.region_done;
   assign rsp_last_record   = out_rec.last_record;

endmodule

@@ sv/trrf_core.sv @@
module trrf_core #(
   parameter int MOTIF_MAX = trrf_pkg::MOTIF_MAX_DEF,
   parameter int POS_WIDTH = trrf_pkg::POS_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        base,
   input  logic              region_end,
   input  trrf_pkg::cfg_type cfg,
   output logic              stage_vld,
   output logic [1:0]        push_cnt,
   output trrf_pkg::rec_type rec0,
   output trrf_pkg::rec_type rec1
);
   import trrf_pkg::*;

   localparam int WIN_DEPTH = MOTIF_MAX + 1;
   localparam int PW        = POS_WIDTH;
   localparam int WW        = (PW > 32) ? PW : 32;
   localparam logic [PW-1:0] POS_MAX = '1;
   localparam logic [7:0] CHAR_LO_A = 8'h61;
   localparam logic [7:0] CHAR_LO_Z = 8'h7A;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   // Input stage
   logic        vld_ff;
   logic [7:0]  base_ff;
   logic        rend_ff;

   // Run state
   logic [7:0]    win_ff [WIN_DEPTH];
   logic [7:0]    win_in [WIN_DEPTH];
   logic [PW-1:0] bpos_ff, bpos_in;
   logic [PW-1:0] nfree_ff, nfree_in;
   logic          ropen_ff, ropen_in;
   logic [PW-1:0] rbgn_ff, rbgn_in;
   logic [31:0]   rcnt_ff, rcnt_in;
   logic [7:0]    lbyte_ff, lbyte_in;
   logic          lvld_ff, lvld_in;
   logic [7:0]    abyte_ff, abyte_in;
   logic          aseen_ff, aseen_in;
   logic [31:0]   mseen_ff, mseen_in;

   // Datapath
   logic [3:0]    len_c;
   logic [7:0]    b_c;
   logic [7:0]    win_nx [WIN_DEPTH];
   logic [MOTIF_MAX:1] hit_l;
   logic          seq_hit;
   logic [7:0]    left_pick;
   logic [PW:0]   pend_c;
   logic [PW:0]   start_w;
   logic [PW-1:0] start_c;
   logic          elig;
   logic          match;
   logic [PW-1:0] bpos_inc;
   logic          emit_a, emit_b;
   rec_type       rec_a, rec_b;

   function automatic logic [31:0] cnt_inc(input logic [31:0] c);
      return (c == CNT_MAX) ? c : c + 32'd1;
   endfunction

   function automatic rec_type make_rec(
      input logic [PW-1:0] bgn,
      input logic [31:0]   cnt,
      input logic [7:0]    lb,
      input logic          lv,
      input logic [7:0]    ab,
      input logic          av,
      input logic [31:0]   ms,
      input logic          done
   );
      rec_type     r;
      logic [WW-1:0] wide;
      wide            = WW'(bgn);
      r.run_start_pos = (wide > WW'(CNT_MAX)) ? CNT_MAX : wide[31:0];
      r.run_repeats   = cnt;
      r.left_base     = lv ? lb : 8'd0;
      r.has_left      = lv;
      r.right_base    = av ? ab : 8'd0;
      r.has_right     = av;
      r.match_total   = ms;
      r.region_done   = done;
      r.last_record   = 1'b0;
      return r;
   endfunction

   // Register the accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= take;
      end
      if (take) begin
         base_ff <= base;
         rend_ff <= region_end;
      end
   end

   assign stage_vld = vld_ff;

   // Clamp motif length, fold case, shift the window
   always_comb begin
      if (cfg.motif_length == 4'd0) begin
         len_c = 4'd1;
      end else if (cfg.motif_length > 4'(MOTIF_MAX)) begin
         len_c = 4'(MOTIF_MAX);
      end else begin
         len_c = cfg.motif_length;
      end
      if (cfg.case_fold && base_ff >= CHAR_LO_A && base_ff <= CHAR_LO_Z) begin
         b_c = base_ff - CASE_GAP;
      end else begin
         b_c = base_ff;
      end
      win_nx[0] = b_c;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win_nx[k] = win_ff[k-1];
      end
   end

   // Compare the window against the motif for every candidate length
   always_comb begin
      for (int l = 1; l <= MOTIF_MAX; l++) begin
         hit_l[l] = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (win_nx[l-1-i] != cfg.motif[8*i +: 8]) begin
               hit_l[l] = 1'b0;
            end
         end
      end
      seq_hit   = 1'b0;
      left_pick = 8'd0;
      for (int l = 1; l <= MOTIF_MAX; l++) begin
         if (len_c == 4'(l)) begin
            seq_hit   = hit_l[l];
            left_pick = win_nx[l];
         end
      end
   end

   // Position checks
   always_comb begin
      pend_c   = {1'b0, bpos_ff} + (PW+1)'(1);
      start_w  = pend_c - (PW+1)'(len_c);
      start_c  = start_w[PW-1:0];
      elig     = (bpos_ff != POS_MAX) && (pend_c >= (PW+1)'(len_c))
                 && (start_w >= {1'b0, nfree_ff});
      match    = elig && seq_hit;
      bpos_inc = (bpos_ff == POS_MAX) ? POS_MAX : bpos_ff + PW'(1);
   end

   // Next state and records
   always_comb begin
      win_in   = win_ff;
      bpos_in  = bpos_ff;
      nfree_in = nfree_ff;
      ropen_in = ropen_ff;
      rbgn_in  = rbgn_ff;
      rcnt_in  = rcnt_ff;
      lbyte_in = lbyte_ff;
      lvld_in  = lvld_ff;
      abyte_in = abyte_ff;
      aseen_in = aseen_ff;
      mseen_in = mseen_ff;
      emit_a   = 1'b0;
      emit_b   = 1'b0;
      rec_a    = make_rec(rbgn_ff, rcnt_ff, lbyte_ff, lvld_ff, abyte_ff, aseen_ff,
                          cnt_inc(mseen_ff), 1'b0);
      rec_b    = rec_a;
      if (vld_ff) begin
         win_in = win_nx;
         if (match) begin
            mseen_in = cnt_inc(mseen_ff);
            if (ropen_ff && start_c == nfree_ff) begin
               // extend the open run
               rcnt_in  = cnt_inc(rcnt_ff);
               aseen_in = 1'b0;
            end else begin
               // close the open run, start a new one
               emit_a   = ropen_ff;
               ropen_in = 1'b1;
               rbgn_in  = start_c;
               rcnt_in  = 32'd1;
               lvld_in  = (start_c != '0);
               lbyte_in = (start_c != '0) ? left_pick : 8'd0;
               abyte_in = 8'd0;
               aseen_in = 1'b0;
            end
            nfree_in = bpos_inc;
         end else if (ropen_ff && !aseen_ff && bpos_ff == nfree_ff) begin
            // catch the byte right after the run
            abyte_in = b_c;
            aseen_in = 1'b1;
         end
         bpos_in = bpos_inc;
         rec_b   = make_rec(rbgn_in, rcnt_in, lbyte_in, lvld_in, abyte_in, aseen_in,
                            mseen_in, 1'b1);
         if (rend_ff) begin
            emit_b = ropen_in;
            for (int k = 0; k < WIN_DEPTH; k++) begin
               win_in[k] = 8'd0;
            end
            bpos_in  = '0;
            nfree_in = '0;
            ropen_in = 1'b0;
            rbgn_in  = '0;
            rcnt_in  = 32'd0;
            lbyte_in = 8'd0;
            lvld_in  = 1'b0;
            abyte_in = 8'd0;
            aseen_in = 1'b0;
            mseen_in = 32'd0;
         end
      end
   end

   // Order records, flag the last of the beat
   always_comb begin
      rec0 = emit_a ? rec_a : rec_b;
      rec0.last_record = emit_a ? !emit_b : 1'b1;
      rec1 = rec_b;
      rec1.last_record = 1'b1;
      push_cnt = 2'(emit_a) + 2'(emit_b);
   end

   // Hold run state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ff[k] <= 8'd0;
         end
         bpos_ff  <= '0;
         nfree_ff <= '0;
         ropen_ff <= 1'b0;
         rbgn_ff  <= '0;
         rcnt_ff  <= 32'd0;
         lbyte_ff <= 8'd0;
         lvld_ff  <= 1'b0;
         abyte_ff <= 8'd0;
         aseen_ff <= 1'b0;
         mseen_ff <= 32'd0;
      end else begin
         win_ff   <= win_in;
         bpos_ff  <= bpos_in;
         nfree_ff <= nfree_in;
         ropen_ff <= ropen_in;
         rbgn_ff  <= rbgn_in;
         rcnt_ff  <= rcnt_in;
         lbyte_ff <= lbyte_in;
         lvld_ff  <= lvld_in;
         abyte_ff <= abyte_in;
         aseen_ff <= aseen_in;
         mseen_ff <= mseen_in;
      end
   end

endmodule

@@ sv/trrf_rsp_queue.sv @@
module trrf_rsp_queue #(
   parameter int DEPTH = trrf_pkg::RSP_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_cnt,
   input  trrf_pkg::rec_type          push0,
   input  trrf_pkg::rec_type          push1,
   input  logic                       pop,
   output logic                       out_valid,
   output trrf_pkg::rec_type          out_rec,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import trrf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   rec_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  wptr_nx;

   assign wptr_nx   = wptr_ff + PTR_W'(1);
   assign out_valid = (cnt_ff != '0);
   assign out_rec   = mem_ff[rptr_ff];
   assign count     = cnt_ff;

   // Advance pointers and fill level
   always_comb begin
      wptr_in = wptr_ff + PTR_W'(push_cnt);
      rptr_in = pop ? rptr_ff + PTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   // Write up to two records a beat
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wptr_nx] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

@@ sv/trrf_checker.sv @@
module trrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_run_start_pos,
   input logic [31:0] rsp_run_repeats,
   input logic [31:0] rsp_match_total,
   input logic        rsp_region_done,
   input logic        rsp_last_record
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_start_pos)
         && $stable(rsp_run_repeats) && $stable(rsp_match_total))
      else $error("stalled rsp beat changed");

   // Nothing comes out right after reset
   a_rst_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

   // A closing record is always the last of its base
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region_done |-> rsp_last_record)
      else $error("region_done without last_record");

   // The partner of a non-last record is already queued
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_record |=> rsp_valid)
      else $error("second record of a base missing");

   // Every reported run holds at least one copy
   a_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_repeats != 32'd0)
      else $error("run with zero repeats");

endmodule

bind tandem_repeat_run_finder trrf_checker u_trrf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_run_start_pos (rsp_run_start_pos),
   .rsp_run_repeats   (rsp_run_repeats),
   .rsp_match_total   (rsp_match_total),
   .rsp_region_done   (rsp_region_done),
   .rsp_last_record   (rsp_last_record)
);

@@ tb/trrf_run_scoreboard.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts the run records of each accepted base and
// compares every accepted record beat against the oldest prediction.
module trrf_run_scoreboard (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_base,
   input  logic              req_region_end,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [31:0]       rsp_run_start_pos,
   input  logic [31:0]       rsp_run_repeats,
   input  logic [7:0]        rsp_left_base,
   input  logic              rsp_has_left,
   input  logic [7:0]        rsp_right_base,
   input  logic              rsp_has_right,
   input  logic [31:0]       rsp_match_total,
   input  logic              rsp_region_done,
   input  logic              rsp_last_record,
   input  trrf_pkg::cfg_type cfg,
   output int                mismatches,
   output int                pending
);
   import trrf_pkg::*;

   localparam int          WIN_DEPTH = MOTIF_MAX_DEF + 1;
   localparam logic [31:0] POS_LIMIT = 32'((64'd1 << POS_WIDTH_DEF) - 64'd1);

   // runs predicted but not yet seen on the result channel
   rec_type     expected_runs[$];

   // region state
   logic [7:0]  window [WIN_DEPTH];
   logic [31:0] pos;
   logic [31:0] free_pos;
   logic        run_live;
   logic [31:0] run_at;
   logic [31:0] run_reps;
   logic [7:0]  left_byte;
   logic        left_ok;
   logic [7:0]  right_byte;
   logic        right_seen;
   logic [31:0] hits;

   function automatic logic [31:0] count_up(logic [31:0] c);
      return (c == CNT_MAX) ? c : c + 32'd1;
   endfunction

   function automatic logic [31:0] pos_up(logic [31:0] p);
      return (p >= POS_LIMIT) ? POS_LIMIT : p + 32'd1;
   endfunction

   task automatic clear_region();
      for (int i = 0; i < WIN_DEPTH; i++) window[i] = 8'd0;
      pos        = '0;
      free_pos   = '0;
      run_live   = 1'b0;
      run_at     = '0;
      run_reps   = '0;
      left_byte  = 8'd0;
      left_ok    = 1'b0;
      right_byte = 8'd0;
      right_seen = 1'b0;
      hits       = '0;
   endtask

   function automatic rec_type run_record(logic done);
      rec_type r;
      r.run_start_pos = run_at;
      r.run_repeats   = run_reps;
      r.left_base     = left_ok ? left_byte : 8'd0;
      r.has_left      = left_ok;
      r.right_base    = right_seen ? right_byte : 8'd0;
      r.has_right     = right_seen;
      r.match_total   = hits;
      r.region_done   = done;
      r.last_record   = 1'b0;
      return r;
   endfunction

   // Advance the region by one base and queue the runs it closes.
   task automatic take_base(input logic [7:0] raw, input logic fin);
      logic [7:0]  b;
      int          len;
      logic [32:0] p1;
      logic [31:0] start;
      logic        hit;
      rec_type     closed[$];
      rec_type     r;

      len = int'(cfg.motif_length);
      if (len == 0) len = 1;
      if (len > MOTIF_MAX_DEF) len = MOTIF_MAX_DEF;
      b = raw;
      if (cfg.case_fold && b >= 8'h61 && b <= 8'h7A) b = b - 8'd32;

      // shift the newest base into the window
      for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;

      // compare the motif against the newest len bases
      p1  = {1'b0, pos} + 33'd1;
      hit = 1'b0;
      if (pos < POS_LIMIT && p1 >= 33'(len) && p1 - 33'(len) >= {1'b0, free_pos}) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++)
            if (window[len - 1 - i] != cfg.motif[8*i +: 8]) hit = 1'b0;
      end

      if (hit) begin
         start = 32'(p1 - 33'(len));
         hits  = count_up(hits);
         if (run_live && start == free_pos) begin
            run_reps   = count_up(run_reps);
            right_seen = 1'b0;
         end else begin
            if (run_live) closed = {closed, run_record(1'b0)};
            run_live   = 1'b1;
            run_at     = start;
            run_reps   = 32'd1;
            left_ok    = start >= 32'd1;
            left_byte  = left_ok ? window[len] : 8'd0;
            right_byte = 8'd0;
            right_seen = 1'b0;
         end
         free_pos = pos_up(pos);
      end else if (run_live && !right_seen && pos == free_pos) begin
         right_byte = b;
         right_seen = 1'b1;
      end

      pos = pos_up(pos);

      // close the region
      if (fin) begin
         if (run_live) closed = {closed, run_record(1'b1)};
         clear_region();
      end

      foreach (closed[i]) begin
         r = closed[i];
         r.last_record = (i == closed.size() - 1);
         expected_runs = {expected_runs, r};
      end
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   task automatic check_beat();
      rec_type want;
      if (expected_runs.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("record beat with none expected: start %0h repeats %0h",
                     rsp_run_start_pos, rsp_run_repeats);
      end else begin
         want = expected_runs.pop_front();
         compare_field("run_start_pos", want.run_start_pos, rsp_run_start_pos);
         compare_field("run_repeats",   want.run_repeats,   rsp_run_repeats);
         compare_field("left_base",     32'(want.left_base),  32'(rsp_left_base));
         compare_field("has_left",      32'(want.has_left),   32'(rsp_has_left));
         compare_field("right_base",    32'(want.right_base), 32'(rsp_right_base));
         compare_field("has_right",     32'(want.has_right),  32'(rsp_has_right));
         compare_field("match_total",   want.match_total,   rsp_match_total);
         compare_field("region_done",   32'(want.region_done), 32'(rsp_region_done));
         compare_field("last_record",   32'(want.last_record), 32'(rsp_last_record));
      end
   endtask

   // Sample both channels at the clock edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_region();
         expected_runs.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) take_base(req_base, req_region_end);
         if (rsp_valid && !rsp_stall) check_beat();
      end
      pending = expected_runs.size();
   end

endmodule

@@ tb/tandem_repeat_run_finder_tb.sv @@
`timescale 1ns / 1ps

module tandem_repeat_run_finder_tb;
   import trrf_pkg::*;

   localparam logic [4:0] MOTIF_ADDR   = 5'h00;
   localparam logic [4:0] LENGTH_ADDR  = 5'h08;
   localparam logic [4:0] FOLD_ADDR    = 5'h10;
   localparam int         RANDOM_ITEMS = 900;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         DRAIN_CYCLES = 6;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam logic [7:0] BASES [4]    = '{8'h41, 8'h43, 8'h47, 8'h54};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_base = 8'd0;
   logic        req_region_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_run_start_pos;
   logic [31:0] rsp_run_repeats;
   logic [7:0]  rsp_left_base;
   logic        rsp_has_left;
   logic [7:0]  rsp_right_base;
   logic        rsp_has_right;
   logic [31:0] rsp_match_total;
   logic        rsp_region_done;
   logic        rsp_last_record;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = 5'd0;
   logic [63:0] pwdata = 64'd0;
   logic [63:0] prdata;
   logic        pready;

   // register values as last written, for the scoreboard
   cfg_type     cfg_now = '{motif: 64'd0, motif_length: 4'd1, case_fold: 1'b0};

   int          mismatches;
   int          pending;
   int          items_sent = 0;
   int          hold_reqs = 0;
   int          hold_taken = 0;
   int          hold_left = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   tandem_repeat_run_finder dut (.*);

   trrf_run_scoreboard run_monitor (.*, .cfg(cfg_now));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stalls, long hold-offs on request, none while calm.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_reqs) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= hold_taken + 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one base, with random idle cycles ahead of it.
   task automatic push_byte(input logic [7:0] b, input logic fin);
      if (!calm) begin
         while ($urandom_range(0, 99) < 15) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_base       <= b;
      req_region_end <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic push_text(input string s, input bit fin);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], fin && i == s.len() - 1);
   endtask

   // Hold the sender until every predicted run has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB write; psel stays high for a following write.
   task automatic csr_write(input logic [4:0] addr, input logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (addr)
         MOTIF_ADDR:  cfg_now.motif        = data;
         LENGTH_ADDR: cfg_now.motif_length = data[3:0];
         FOLD_ADDR:   cfg_now.case_fold    = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [63:0] m, input int len, input bit fold);
      csr_write(MOTIF_ADDR, m);
      csr_write(LENGTH_ADDR, 64'(len));
      csr_write(FOLD_ADDR, 64'(fold));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Lower an upper-case letter now and then, mostly when folding is on.
   function automatic logic [7:0] shape(logic [7:0] b, bit fold);
      if (b >= 8'h41 && b <= 8'h5A && $urandom_range(0, 99) < (fold ? 50 : 3))
         return b + 8'd32;
      return b;
   endfunction

   // Build one region from motif copies, partial copies, filler and noise.
   task automatic push_region(input logic [63:0] m, input int eff, input bit fold,
                              input bit fin);
      logic [7:0] bytes[$];
      int         target;
      int         copies;
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 30);
      while (bytes.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               copies = $urandom_range(1, 4);
               repeat (copies)
                  for (int i = 0; i < eff; i++) bytes = {bytes, shape(m[8*i +: 8], fold)};
            end
            5: begin
               copies = $urandom_range(0, eff - 1);
               for (int i = 0; i < copies; i++) bytes = {bytes, shape(m[8*i +: 8], fold)};
            end
            6, 7, 8: begin
               repeat ($urandom_range(1, 3))
                  bytes = {bytes, shape(BASES[$urandom_range(0, 3)], fold)};
            end
            default: bytes = {bytes, 8'($urandom_range(0, 255))};
         endcase
      end
      foreach (bytes[i]) push_byte(bytes[i], fin && i == bytes.size() - 1);
   endtask

   initial begin
      logic [63:0] m;
      int          len;
      int          eff;
      bit          fold;
      int          phase;
      int          regions;
      int          directed_items;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: motif of one zero byte
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);

      // abutting copies, a gap, then a second run closed by the region end
      drain();
      set_config(64'h4341, 2, 1'b0);
      push_text("ACACGAC", 1'b1);

      // folded input with a left neighbor
      drain();
      set_config(64'h4341, 2, 1'b1);
      push_text("xacac", 1'b1);

      // zero length acts as one; one base closes a run and opens the next
      drain();
      set_config(64'h54, 0, 1'b0);
      push_text("TTGT", 1'b1);

      // all-ones motif, length beyond the maximum clamps to eight
      drain();
      set_config('1, 15, 1'b1);
      repeat (8) push_byte(8'hFF, 1'b0);
      push_byte(8'h61, 1'b1);

      directed_items = items_sent;
      phase = 0;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         phase++;
         drain();
         if (phase == 4) begin
            // one record per base while the receiver holds off
            set_config(64'h41, 1, 1'b0);
            hold_reqs <= hold_reqs + 1;
            repeat (40) push_byte(8'h41, 1'b1);
         end else begin
            calm = (phase == 7);
            if ($urandom_range(0, 7) == 0)
               m = {$urandom, $urandom};
            else
               for (int i = 0; i < 8; i++) m[8*i +: 8] = BASES[$urandom_range(0, 3)];
            case ($urandom_range(0, 19)) inside
               [0:13]:  len = $urandom_range(1, 4);
               [14:16]: len = $urandom_range(5, 8);
               default: len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
            endcase
            fold = $urandom_range(0, 1);
            set_config(m, len, fold);
            eff = (len == 0) ? 1 : (len > MOTIF_MAX_DEF) ? MOTIF_MAX_DEF : len;
            regions = (phase == 7) ? 8 : $urandom_range(1, 4);
            // the last region may stay open across the next register change
            for (int r = 0; r < regions; r++)
               push_region(m, eff, fold, (r < regions - 1) || ($urandom_range(0, 4) != 0));
            calm = 1'b0;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/trrf_pkg.sv
sv/trrf_core.sv
sv/trrf_rsp_queue.sv
sv/tandem_repeat_run_finder.sv
sv/trrf_checker.sv
tb/trrf_run_scoreboard.sv
tb/tandem_repeat_run_finder_tb.sv
